### rtl/pfse_pkg.sv
// ----------------------------------------------------------------------------
// pfse_pkg : shared types and constants for the Playfair stream encryptor
// Key square layout, register indexes, reset square and the cell search.
// ----------------------------------------------------------------------------
`default_nettype none

package pfse_pkg;

	localparam int SQ_DIM = 5;

	// letter index A=0 .. Z=25, one 5-bit cell
	typedef logic [4:0] letter_t;
	// one row: cell j at bits 5j
	typedef logic [SQ_DIM-1:0][4:0] sq_row_t;
	// whole square: [row][col]
	typedef logic [SQ_DIM-1:0][SQ_DIM-1:0][4:0] square_t;
	// row or column position inside the square
	typedef logic [2:0] pos_t;

	localparam letter_t PAD_LETTER = 5'd23;   // 'X'
	localparam logic [7:0] ASCII_UPPER_A = 8'd65;
	localparam logic [7:0] ASCII_UPPER_Z = 8'd90;
	localparam logic [7:0] ASCII_LOWER_A = 8'd97;
	localparam logic [7:0] ASCII_LOWER_Z = 8'd122;

	// configuration register indexes
	typedef logic [2:0] cfg_index_t;
	localparam cfg_index_t CFG_SQUARE_ROW_0 = 3'd0;
	localparam cfg_index_t CFG_SQUARE_ROW_1 = 3'd1;
	localparam cfg_index_t CFG_SQUARE_ROW_2 = 3'd2;
	localparam cfg_index_t CFG_SQUARE_ROW_3 = 3'd3;
	localparam cfg_index_t CFG_SQUARE_ROW_4 = 3'd4;

	// reset square MFHIJ / UNOPQ / ZVWXY / ELARG / DSTBC
	localparam sq_row_t SQUARE_ROW_0_RST = 25'd9706668;
	localparam sq_row_t SQUARE_ROW_1_RST = 25'd17283508;
	localparam sq_row_t SQUARE_ROW_2_RST = 25'd25942713;
	localparam sq_row_t SQUARE_ROW_3_RST = 25'd6848868;
	localparam sq_row_t SQUARE_ROW_4_RST = 25'd2149955;

	typedef struct packed {
		logic found;
		pos_t row;
		pos_t col;
	} loc_t;

	// pair handed from the pair register to the result stage
	typedef struct packed {
		letter_t first;
		letter_t second;
		logic    present;
		logic    last;
	} pair_t;

	// parallel compare of all 25 cells; first match in row-major order wins
	function automatic loc_t locate(input square_t sq, input letter_t letter);
		loc_t loc;
		loc = '0;
		for (int r = SQ_DIM - 1; r >= 0; r--) begin
			for (int c = SQ_DIM - 1; c >= 0; c--) begin
				if (sq[r][c] == letter) begin
					loc.found = 1'b1;
					loc.row   = pos_t'(r);
					loc.col   = pos_t'(c);
				end
			end
		end
		return loc;
	endfunction

	// step one position with wrap
	function automatic pos_t pos_next(input pos_t p);
		return (p == pos_t'(SQ_DIM - 1)) ? '0 : p + 3'd1;
	endfunction

endpackage

`default_nettype wire

### rtl/playfair_stream_encryptor.sv
// ----------------------------------------------------------------------------
// playfair_stream_encryptor : byte stream Playfair encryptor
// Filters letters, pairs them, and encrypts each pair with a 5x5 key square.
// ----------------------------------------------------------------------------
//  channel | direction | words carried
//  --------+-----------+------------------------------------------------------
//  s_axis  | in        | text byte, end of text on tlast
//  m_axis  | out       | cipher pair, flags on tuser, last of message on tlast
//  cfg     | in        | key square row writes, index 0..4, no read-back
//
//  One byte per cycle sustained while m_axis is not stalled. A word that yields a
//  result is taken into the pair register (_s1) at the accepting edge, and then
//  into the result register (_q), fed by the 25-cell parallel match, which drives
//  m_axis. Words that yield nothing only update the held letter. arst_n clears
//  the pipeline and the held letter and reloads the reset square. A stall on
//  m_axis backs up one word into the pair register before s_axis_tready drops.
// ----------------------------------------------------------------------------
`default_nettype none

module playfair_stream_encryptor
	import pfse_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,

	input  wire logic        s_axis_tvalid,
	output      logic        s_axis_tready,
	input  wire logic [7:0]  s_axis_tdata,   // [7:0] text_byte
	input  wire logic        s_axis_tlast,   // end_of_text

	output      logic        m_axis_tvalid,
	input  wire logic        m_axis_tready,
	output      logic [15:0] m_axis_tdata,   // [7:0] cipher_first, [15:8] cipher_second
	output      logic [1:0]  m_axis_tuser,   // [0] pair_present, [1] not_in_square
	output      logic        m_axis_tlast,   // last_of_message

	input  wire logic        cfg_we,
	input  wire cfg_index_t  cfg_index,
	input  wire logic [24:0] cfg_data
);

	// key square
	square_t sq_q;

	// held first letter of a pair
	letter_t held_q;
	logic    pending_q;

	// pair register
	logic  valid_s1;
	pair_t pair_s1;

	// result register
	logic [7:0] first_q;
	logic [7:0] second_q;
	logic       present_q;
	logic       miss_q;
	logic       last_q;

	// ---------------------------------------------------------------- handshake
	logic out_free;
	logic adv_s1;
	logic accept;

	assign out_free      = !m_axis_tvalid || m_axis_tready;
	assign adv_s1        = valid_s1 && out_free;
	assign s_axis_tready = !valid_s1 || out_free;
	assign accept        = s_axis_tvalid && s_axis_tready;

	// ---------------------------------------------------------------- decode
	logic    is_upper;
	logic    is_lower;
	logic    is_letter;
	letter_t letter;
	logic    has_result;
	pair_t   pair_d;
	logic    pending_d;

	always_comb begin
		is_upper  = (s_axis_tdata >= ASCII_UPPER_A) && (s_axis_tdata <= ASCII_UPPER_Z);
		is_lower  = (s_axis_tdata >= ASCII_LOWER_A) && (s_axis_tdata <= ASCII_LOWER_Z);
		is_letter = is_upper || is_lower;
		letter    = is_lower ? letter_t'(s_axis_tdata - ASCII_LOWER_A)
		                     : letter_t'(s_axis_tdata - ASCII_UPPER_A);

		pair_d     = '0;
		has_result = 1'b0;
		pending_d  = pending_q;

		if (is_letter && pending_q) begin
			// second letter completes the held pair
			has_result     = 1'b1;
			pair_d.first   = held_q;
			pair_d.second  = letter;
			pair_d.present = 1'b1;
			pair_d.last    = s_axis_tlast;
			pending_d      = 1'b0;
		end else if (is_letter) begin
			// first letter: hold it, or pad it with X on the end byte
			pending_d = !s_axis_tlast;
			if (s_axis_tlast) begin
				has_result     = 1'b1;
				pair_d.first   = letter;
				pair_d.second  = PAD_LETTER;
				pair_d.present = 1'b1;
				pair_d.last    = 1'b1;
			end
		end else if (s_axis_tlast) begin
			// end byte that is no letter: flush a held letter or send a bare marker
			has_result     = 1'b1;
			pair_d.first   = pending_q ? held_q : '0;
			pair_d.second  = pending_q ? PAD_LETTER : '0;
			pair_d.present = pending_q;
			pair_d.last    = 1'b1;
			pending_d      = 1'b0;
		end
	end

	// ---------------------------------------------------------------- letter state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			held_q    <= '0;
			pending_q <= 1'b0;
		end else if (accept) begin
			pending_q <= pending_d;
			if (is_letter && !pending_q) begin
				held_q <= letter;
			end
		end
	end

	// ---------------------------------------------------------------- key square
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sq_q[0] <= SQUARE_ROW_0_RST;
			sq_q[1] <= SQUARE_ROW_1_RST;
			sq_q[2] <= SQUARE_ROW_2_RST;
			sq_q[3] <= SQUARE_ROW_3_RST;
			sq_q[4] <= SQUARE_ROW_4_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_SQUARE_ROW_0: sq_q[0] <= cfg_data;
				CFG_SQUARE_ROW_1: sq_q[1] <= cfg_data;
				CFG_SQUARE_ROW_2: sq_q[2] <= cfg_data;
				CFG_SQUARE_ROW_3: sq_q[3] <= cfg_data;
				CFG_SQUARE_ROW_4: sq_q[4] <= cfg_data;
				default: ;  // drop writes beyond the register list
			endcase
		end
	end

	// ---------------------------------------------------------------- pair register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= has_result;
		end else if (adv_s1) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept && has_result) begin
			pair_s1 <= pair_d;
		end
	end

	// ---------------------------------------------------------------- encrypt
	loc_t    loc_a;
	loc_t    loc_b;
	logic    both_found;
	letter_t enc_a;
	letter_t enc_b;

	always_comb begin
		loc_a      = locate(sq_q, pair_s1.first);
		loc_b      = locate(sq_q, pair_s1.second);
		both_found = loc_a.found && loc_b.found;

		if (!both_found) begin
			// pass the pair through unchanged
			enc_a = pair_s1.first;
			enc_b = pair_s1.second;
		end else if (loc_a.row == loc_b.row) begin
			// same row: shift right
			enc_a = sq_q[loc_a.row][pos_next(loc_a.col)];
			enc_b = sq_q[loc_b.row][pos_next(loc_b.col)];
		end else if (loc_a.col == loc_b.col) begin
			// same column: shift down
			enc_a = sq_q[pos_next(loc_a.row)][loc_a.col];
			enc_b = sq_q[pos_next(loc_b.row)][loc_b.col];
		end else begin
			// rectangle: swap columns
			enc_a = sq_q[loc_a.row][loc_b.col];
			enc_b = sq_q[loc_b.row][loc_a.col];
		end
	end

	// ---------------------------------------------------------------- result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_axis_tvalid <= 1'b0;
		end else if (out_free) begin
			m_axis_tvalid <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1) begin
			present_q <= pair_s1.present;
			last_q    <= pair_s1.last;
			if (pair_s1.present) begin
				first_q  <= ASCII_UPPER_A + {3'b000, enc_a};
				second_q <= ASCII_UPPER_A + {3'b000, enc_b};
				miss_q   <= !both_found;
			end else begin
				// bare end marker carries zeros
				first_q  <= '0;
				second_q <= '0;
				miss_q   <= 1'b0;
			end
		end
	end

	assign m_axis_tdata = {second_q, first_q};
	assign m_axis_tuser = {miss_q, present_q};
	assign m_axis_tlast = last_q;

endmodule

`default_nettype wire

### rtl/pfse_checker.sv
// ----------------------------------------------------------------------------
// pfse_checker : port-level checks for the Playfair stream encryptor
// Watches the result channel and flags broken result words.
// ----------------------------------------------------------------------------
`default_nettype none

module pfse_checker
	import pfse_pkg::*;
(
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        m_axis_tvalid,
	input wire logic        m_axis_tready,
	input wire logic [15:0] m_axis_tdata,
	input wire logic [1:0]  m_axis_tuser,
	input wire logic        m_axis_tlast
);

	// hold a stalled result word
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=>
			m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser)
			&& $stable(m_axis_tlast))
		else $error("result word changed while stalled");

	// a bare end marker carries zeros and closes the message
	a_marker: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tuser[0] |->
			m_axis_tdata == 16'd0 && m_axis_tlast && !m_axis_tuser[1])
		else $error("malformed end marker");

	// cipher bytes stay in 'A' plus a 5-bit cell value
	a_range: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tuser[0] |->
			m_axis_tdata[7:0] >= ASCII_UPPER_A && m_axis_tdata[7:0] <= 8'd96
			&& m_axis_tdata[15:8] >= ASCII_UPPER_A && m_axis_tdata[15:8] <= 8'd96)
		else $error("cipher byte out of range");

	// a pass-through pair holds two real letters
	a_miss: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tuser[1] |->
			m_axis_tuser[0] && m_axis_tdata[7:0] <= ASCII_UPPER_Z
			&& m_axis_tdata[15:8] <= ASCII_UPPER_Z)
		else $error("not_in_square word is malformed");

endmodule

bind playfair_stream_encryptor pfse_checker u_pfse_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.m_axis_tvalid (m_axis_tvalid),
	.m_axis_tready (m_axis_tready),
	.m_axis_tdata  (m_axis_tdata),
	.m_axis_tuser  (m_axis_tuser),
	.m_axis_tlast  (m_axis_tlast)
);

`default_nettype wire

### tb/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top : self-checking bench for the Playfair stream encryptor
// Streams text bytes through the block under several key squares. Each
// accepted byte goes through a cipher model, and every output word is
// compared field by field against the oldest predicted pair.
// ----------------------------------------------------------------------------

module tb_top;
	import pfse_pkg::*;

	localparam int CLK_PERIOD    = 10;
	localparam int RESET_CYCLES  = 12;
	localparam int RANDOM_ITEMS  = 1240;   // words of the random part, noise bytes included
	localparam int PHASE_ITEMS   = 160;
	localparam int DRAIN_CYCLES  = 6;      // settle time after the last result is in
	localparam int RX_HOLD_CYCLES = 300;
	localparam int RESULT_WAIT   = 5000;
	localparam int LIMIT_CYCLES  = 400000;
	// write index with no register behind it; the block must ignore it
	localparam cfg_index_t CFG_NO_REGISTER = 3'd7;

	// one output word as the block should present it
	typedef struct packed {
		logic [7:0] ciph_first;
		logic [7:0] ciph_second;
		logic       pair_present;
		logic       not_in_square;
		logic       is_last;
	} cipher_word_t;

	// one pending input word
	typedef struct packed {
		logic [7:0] text_byte;
		logic       end_of_text;
	} text_word_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;

	logic        s_axis_tvalid = 1'b0;
	logic        s_axis_tready;
	logic [7:0]  s_axis_tdata = '0;       // [7:0] text_byte
	logic        s_axis_tlast = 1'b0;     // end_of_text

	logic        m_axis_tvalid;
	logic        m_axis_tready = 1'b0;
	logic [15:0] m_axis_tdata;            // [7:0] cipher_first, [15:8] cipher_second
	logic [1:0]  m_axis_tuser;            // [0] pair_present, [1] not_in_square
	logic        m_axis_tlast;            // last_of_message

	logic        cfg_we = 1'b0;
	cfg_index_t  cfg_index = CFG_SQUARE_ROW_0;
	logic [24:0] cfg_data = '0;

	// bench state
	text_word_t   text_q[$];       // bytes waiting for the driver
	cipher_word_t pair_q[$];       // predicted output words, oldest first
	int           words_queued = 0;
	int           words_accepted = 0;
	int           stim_count = 0;  // words pushed
	int           err_cnt = 0;
	int           cycle_cnt = 0;
	bit           no_idle = 1'b0;
	bit           rx_hold_go = 1'b0;
	int           rx_hold_cnt = 0;

	// cipher model state
	square_t      key_square;
	letter_t      held_model = '0;
	bit           pending_model = 1'b0;

	playfair_stream_encryptor DUT (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tlast  (s_axis_tlast),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser),
		.m_axis_tlast  (m_axis_tlast),
		.cfg_we        (cfg_we),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data)
	);

	always #(CLK_PERIOD / 2) clk = ~clk;

	// ------------------------------------------------------------------------
	// Cipher model
	// ------------------------------------------------------------------------

	// first cell in row-major order holding the letter
	function automatic void find_letter(input letter_t l, output bit hit,
			output int row, output int col);
		hit = 1'b0;
		row = 0;
		col = 0;
		for (int r = 0; r < SQ_DIM; r++) begin
			for (int c = 0; c < SQ_DIM; c++) begin
				if (!hit && key_square[r][c] == l) begin
					hit = 1'b1;
					row = r;
					col = c;
				end
			end
		end
	endfunction

	function automatic cipher_word_t encrypt_pair(input letter_t a, input letter_t b,
			input logic is_last);
		int ra, ca, rb, cb;
		bit fa, fb;
		letter_t ea, eb;
		cipher_word_t w;
		find_letter(a, fa, ra, ca);
		find_letter(b, fb, rb, cb);
		if (!(fa && fb)) begin
			// letter absent: pass the pair through as uppercase
			ea = a;
			eb = b;
		end else if (ra == rb) begin
			ea = key_square[ra][(ca + 1) % SQ_DIM];
			eb = key_square[rb][(cb + 1) % SQ_DIM];
		end else if (ca == cb) begin
			ea = key_square[(ra + 1) % SQ_DIM][ca];
			eb = key_square[(rb + 1) % SQ_DIM][cb];
		end else begin
			ea = key_square[ra][cb];
			eb = key_square[rb][ca];
		end
		// a cell above 25 yields a byte past 'Z'; keep the plain 8-bit sum
		w.ciph_first    = ASCII_UPPER_A + {3'b000, ea};
		w.ciph_second   = ASCII_UPPER_A + {3'b000, eb};
		w.pair_present  = 1'b1;
		w.not_in_square = !(fa && fb);
		w.is_last       = is_last;
		return w;
	endfunction

	function automatic bit is_letter(input logic [7:0] b);
		return (b >= ASCII_UPPER_A && b <= ASCII_UPPER_Z) ||
			(b >= ASCII_LOWER_A && b <= ASCII_LOWER_Z);
	endfunction

	// advance the model by one accepted text word
	task automatic predict_word(input logic [7:0] b, input logic eot);
		letter_t l;
		cipher_word_t empty_end;
		empty_end = '{ciph_first: 8'd0, ciph_second: 8'd0, pair_present: 1'b0,
			not_in_square: 1'b0, is_last: 1'b1};
		if (is_letter(b)) begin
			l = (b <= ASCII_UPPER_Z) ? letter_t'(b - ASCII_UPPER_A) :
				letter_t'(b - ASCII_LOWER_A);
			if (pending_model) begin
				// second letter: the pair goes out, end flag rides along
				pair_q.push_back(encrypt_pair(held_model, l, eot));
				pending_model = 1'b0;
				return;
			end
			held_model = l;
			pending_model = 1'b1;
		end
		if (!eot)
			return;
		if (pending_model) begin
			// odd letter at end of text: pad with X
			pair_q.push_back(encrypt_pair(held_model, PAD_LETTER, 1'b1));
			pending_model = 1'b0;
		end else begin
			pair_q.push_back(empty_end);
		end
	endtask

	// ------------------------------------------------------------------------
	// Driver: offer queued bytes, idle at random unless told not to
	// ------------------------------------------------------------------------
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s_axis_tvalid <= 1'b0;
			s_axis_tdata  <= '0;
			s_axis_tlast  <= 1'b0;
		end else begin
			if (s_axis_tvalid && s_axis_tready) begin
				predict_word(s_axis_tdata, s_axis_tlast);
				words_accepted++;
			end
			// load the next word once the current one is gone
			if (!s_axis_tvalid || s_axis_tready) begin
				if (text_q.size() != 0 && (no_idle || $urandom_range(99) >= 30)) begin
					s_axis_tvalid <= 1'b1;
					s_axis_tdata  <= text_q[0].text_byte;
					s_axis_tlast  <= text_q[0].end_of_text;
					void'(text_q.pop_front());
				end else begin
					s_axis_tvalid <= 1'b0;
				end
			end
		end
	end

	// ------------------------------------------------------------------------
	// Receiver hold-off: count down a long stall once requested
	// ------------------------------------------------------------------------
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rx_hold_cnt <= 0;
		end else if (rx_hold_go) begin
			rx_hold_cnt <= RX_HOLD_CYCLES;
		end else if (rx_hold_cnt != 0) begin
			rx_hold_cnt <= rx_hold_cnt - 1;
		end
	end

	task automatic report(input string what, input logic [15:0] got,
			input logic [15:0] want);
		$display("[%0t] mismatch %s: got %h expected %h", $realtime, what, got, want);
		err_cnt++;
	endtask

	// ------------------------------------------------------------------------
	// Monitor: check each output word against the oldest prediction
	// ------------------------------------------------------------------------
	always @(posedge clk or negedge arst_n) begin
		cipher_word_t want;
		if (!arst_n) begin
			m_axis_tready <= 1'b0;
		end else begin
			if (m_axis_tvalid && m_axis_tready) begin
				if (pair_q.size() == 0) begin
					report("unexpected word", m_axis_tdata, 16'h0);
				end else begin
					want = pair_q.pop_front();
					if (m_axis_tdata[7:0] !== want.ciph_first)
						report("cipher_first", m_axis_tdata[7:0], want.ciph_first);
					if (m_axis_tdata[15:8] !== want.ciph_second)
						report("cipher_second", m_axis_tdata[15:8], want.ciph_second);
					if (m_axis_tuser[0] !== want.pair_present)
						report("pair_present", m_axis_tuser[0], want.pair_present);
					if (m_axis_tuser[1] !== want.not_in_square)
						report("not_in_square", m_axis_tuser[1], want.not_in_square);
					if (m_axis_tlast !== want.is_last)
						report("last_of_message", m_axis_tlast, want.is_last);
				end
			end
			m_axis_tready <= (rx_hold_cnt == 0) && (no_idle || $urandom_range(99) >= 30);
		end
	end

	// ------------------------------------------------------------------------
	// Watchdog
	// ------------------------------------------------------------------------
	always @(posedge clk) begin
		cycle_cnt <= cycle_cnt + 1;
		if (cycle_cnt >= LIMIT_CYCLES) begin
			$display("== FAIL ==");
			$finish;
		end
	end

	// ------------------------------------------------------------------------
	// Stimulus helpers
	// ------------------------------------------------------------------------
	task automatic push_text(input logic [7:0] b, input logic eot);
		text_q.push_back('{text_byte: b, end_of_text: eot});
		words_queued++;
		stim_count++;
	endtask

	task automatic push_string(input string s, input bit eot_on_last);
		for (int i = 0; i < s.len(); i++)
			push_text(s[i], eot_on_last && (i == s.len() - 1));
	endtask

	// random message: mostly letters of both cases, some noise bytes
	task automatic push_message(input int len);
		int pick;
		logic [7:0] b;
		for (int i = 0; i < len; i++) begin
			pick = $urandom_range(99);
			if (pick < 40)
				b = ASCII_UPPER_A + 8'($urandom_range(25));
			else if (pick < 75)
				b = ASCII_LOWER_A + 8'($urandom_range(25));
			else
				b = 8'($urandom_range(255));
			push_text(b, i == len - 1);
		end
	endtask

	// hold until every queued word is taken and every result is in,
	// then let the pipeline settle before touching the registers
	task automatic wait_drained();
		int waited;
		waited = 0;
		do @(posedge clk); while (words_accepted != words_queued);
		while (pair_q.size() != 0 && waited < RESULT_WAIT) begin
			@(posedge clk);
			waited++;
		end
		if (pair_q.size() != 0) begin
			report("missing results", 16'(pair_q.size()), 16'h0);
			pair_q.delete();
		end
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic write_row(input cfg_index_t idx, input logic [24:0] val);
		@(posedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		@(posedge clk);
		cfg_we    <= 1'b0;
		if (idx <= CFG_SQUARE_ROW_4)
			key_square[idx] = val;
	endtask

	task automatic load_square(input square_t sq);
		for (int r = 0; r < SQ_DIM; r++)
			write_row(cfg_index_t'(CFG_SQUARE_ROW_0 + r), sq[r]);
		// a write to an unmapped index must leave the square alone
		if ($urandom_range(2) == 0)
			write_row(CFG_NO_REGISTER, 25'($urandom));
	endtask

	// shuffled alphabet, one letter left out; sometimes corrupt a few cells
	// with duplicates or values past Z
	task automatic random_square(output square_t sq);
		letter_t deck [26];
		letter_t tmp;
		int j;
		for (int i = 0; i < 26; i++)
			deck[i] = letter_t'(i);
		for (int i = 25; i > 0; i--) begin
			j = $urandom_range(i);
			tmp = deck[i];
			deck[i] = deck[j];
			deck[j] = tmp;
		end
		for (int r = 0; r < SQ_DIM; r++)
			for (int c = 0; c < SQ_DIM; c++)
				sq[r][c] = deck[r * SQ_DIM + c];
		if ($urandom_range(3) == 0)
			repeat ($urandom_range(1, 4))
				sq[$urandom_range(4)][$urandom_range(4)] = letter_t'($urandom_range(31));
	endtask

	// ------------------------------------------------------------------------
	// Test sequence
	// ------------------------------------------------------------------------
	initial begin
		square_t sq;
		int target;
		int phase;

		key_square[0] = SQUARE_ROW_0_RST;
		key_square[1] = SQUARE_ROW_1_RST;
		key_square[2] = SQUARE_ROW_2_RST;
		key_square[3] = SQUARE_ROW_3_RST;
		key_square[4] = SQUARE_ROW_4_RST;

		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		// Directed part on the reset square (MFHIJ / UNOPQ / ZVWXY / ELARG / DSTBC)
		push_string("MF", 1'b0);       // same row
		push_string("mu", 1'b0);       // same column, lowercase
		push_string("He", 1'b0);       // rectangle
		push_text("A", 1'b0);          // doubled letter split by noise bytes
		push_text(8'h40, 1'b0);
		push_text(8'h5B, 1'b0);
		push_text(8'h60, 1'b0);
		push_text(8'h7B, 1'b0);
		push_text(8'h00, 1'b0);
		push_text(8'hFF, 1'b0);
		push_text("a", 1'b0);
		push_string("Kz", 1'b0);       // K is not in the square
		push_string("Cd", 1'b1);       // pair completed on the end byte, row wrap
		push_text(8'h2E, 1'b1);        // end with nothing held
		push_text("Y", 1'b1);          // odd letter at end, pad with X
		push_text("q", 1'b0);          // odd letter, end carried by a noise byte
		push_text(8'h20, 1'b1);
		push_string("Zx", 1'b1);       // same row
		wait_drained();

		// Register extremes: every cell A, then every cell 31 (nothing matches)
		load_square('0);
		push_message(12);
		push_string("AAb", 1'b1);
		wait_drained();
		load_square('1);
		push_message(12);
		wait_drained();

		// Random part: a fresh square per phase, random messages within
		stim_count = 0;
		phase = 0;
		while (stim_count < RANDOM_ITEMS) begin
			random_square(sq);
			load_square(sq);
			if (phase == 2)
				no_idle <= 1'b1;
			target = stim_count + PHASE_ITEMS;
			if (target > RANDOM_ITEMS)
				target = RANDOM_ITEMS;
			while (stim_count < target)
				push_message($urandom_range(1, 24));
			if (phase == 1) begin
				// stall the receiver while the sender keeps offering bytes
				rx_hold_go <= 1'b1;
				@(posedge clk);
				rx_hold_go <= 1'b0;
			end
			wait_drained();
			no_idle <= 1'b0;
			phase++;
		end

		if (err_cnt == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

endmodule
